[rtl/ssp_pkg.sv]
package ssp_pkg;

	localparam int OP_BITS        = 3;
	localparam int ARG_BITS       = 11;
	localparam int ARG_TDATA_BITS = 16;
	localparam int CFG_IDX_BITS   = 2;
	localparam int SPEED_NUM      = 500;
	localparam int QUO_BITS       = 9;
	localparam int PWM_OFFSET     = 284;

	typedef enum logic [OP_BITS-1:0] {
		OP_TICK  = 3'd0,
		OP_ABS   = 3'd1,
		OP_REL   = 3'd2,
		OP_SPEED = 3'd3,
		OP_STOP  = 3'd4,
		OP_SET   = 3'd5,
		OP_HOME  = 3'd6
	} opcode_t;

	localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP  = 2'd2;

	typedef struct packed {
		logic latch;
		logic div_start;
		logic exec;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic in_is_speed;
		logic div_done;
	} dp_status_t;

endpackage

[rtl/ssp_div.sv]
module ssp_div import ssp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ARG_BITS-1:0] divisor,
	output logic                done,
	output logic [QUO_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(QUO_BITS + 1);
	localparam int IDX_BITS = $clog2(QUO_BITS);
	localparam logic [QUO_BITS-1:0] DIVIDEND = QUO_BITS'(SPEED_NUM);

	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [ARG_BITS-1:0] div_q;
	logic [ARG_BITS-1:0] rem_q;
	logic [QUO_BITS-1:0] quo_q;

	logic [IDX_BITS-1:0] bit_idx;
	logic [ARG_BITS:0]   trial;
	logic                ge;

	// restoring division, one quotient bit per cycle, MSB first
	assign bit_idx = IDX_BITS'(cnt_q - 1'b1);
	assign trial   = {rem_q, DIVIDEND[bit_idx]};
	assign ge      = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_BITS'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_BITS'(QUO_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits the divisor width
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? ARG_BITS'(trial - {1'b0, div_q}) : trial[ARG_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/ssp_ctrl.sv]
module ssp_ctrl import ssp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_EXEC = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign cmd.latch     = accept;
	assign cmd.div_start = accept && status.in_is_speed;
	assign cmd.exec      = (state_q == S_EXEC);
	assign cmd.load_out  = (state_q == S_RESP) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = status.in_is_speed ? S_DIV : S_EXEC;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("result loaded but not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_out && out_valid_q && !m_tready))
		else $error("pending result overwritten");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second transaction taken while busy");

	a_div_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && status.div_done) |=> cmd.exec)
		else $error("division result not applied");

endmodule

[rtl/ssp_datapath.sv]
module ssp_datapath import ssp_pkg::*; #(
	parameter int POS_BITS      = 9,
	parameter int INTERVAL_BITS = 10,
	localparam int CFG_BITS = (POS_BITS > INTERVAL_BITS) ? POS_BITS : INTERVAL_BITS,
	localparam int RAW_BITS = 3 * POS_BITS + 5,
	localparam int OUT_BITS = ((RAW_BITS + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic [OP_BITS-1:0]      in_opcode,
	input  logic [ARG_BITS-1:0]     in_argument,
	input  dp_cmd_t                 cmd,
	output dp_status_t              status,
	output logic [OUT_BITS-1:0]     result
);

	localparam int W  = ((POS_BITS > ARG_BITS) ? POS_BITS : ARG_BITS) + 2;
	localparam int QW = (QUO_BITS > INTERVAL_BITS) ? QUO_BITS : INTERVAL_BITS;
	localparam logic [INTERVAL_BITS-1:0] IVL_MAX = {INTERVAL_BITS{1'b1}};

	// configuration
	logic signed [POS_BITS-1:0]  upper_q, lower_q;
	logic [INTERVAL_BITS-1:0]    step_ivl_q;

	// servo state
	logic signed [POS_BITS-1:0]  pos_q, tgt_q;
	logic [INTERVAL_BITS-1:0]    active_q, cd_q;
	logic                        posmode_q, dir_q;

	// latched command, per-item flag, result
	opcode_t                     op_q;
	logic signed [ARG_BITS-1:0]  arg_q;
	logic                        written_q;
	logic [OUT_BITS-1:0]         result_q;

	logic signed [POS_BITS-1:0]  pos_d, tgt_d;
	logic [INTERVAL_BITS-1:0]    active_d, cd_d;
	logic                        posmode_d, dir_d, written_d;

	logic signed [W-1:0]         pos_w, tgt_w, arg_w, up_w, lo_w;
	logic signed [W-1:0]         np_w, mv_w, diff_w, dist_w, pwm_w;
	logic                        stopped_now, home_ok;

	logic signed [ARG_BITS:0]    in_arg_x;
	logic signed [ARG_BITS:0]    in_arg_neg;
	logic [ARG_BITS-1:0]         mag;
	logic                        div_done;
	logic [QUO_BITS-1:0]         quotient;
	logic [QW-1:0]               quo_w;
	logic [INTERVAL_BITS-1:0]    speed_ivl;

	function automatic logic in_limits(input logic signed [W-1:0] v,
	                                   input logic signed [W-1:0] up,
	                                   input logic signed [W-1:0] lo);
		return !(v > up) && !(v < lo);
	endfunction

	// upper limit applies first, then lower
	function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] v,
	                                              input logic signed [W-1:0] up,
	                                              input logic signed [W-1:0] lo);
		logic signed [W-1:0] t;
		t = (v > up) ? up : v;
		t = (t < lo) ? lo : t;
		return t;
	endfunction

	// speed magnitude straight from the input bus so the divider starts on accept
	assign in_arg_x   = (ARG_BITS + 1)'($signed(in_argument));
	assign in_arg_neg = -in_arg_x;
	assign mag        = in_arg_x[ARG_BITS] ? in_arg_neg[ARG_BITS-1:0] : in_argument;

	ssp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (mag),
		.done     (div_done),
		.quotient (quotient)
	);

	assign status.in_is_speed = (in_opcode == OP_SPEED);
	assign status.div_done    = div_done;

	assign quo_w     = QW'(quotient);
	assign speed_ivl = (arg_q == '0) ? '0 :
	                   (quo_w > QW'(IVL_MAX)) ? IVL_MAX : INTERVAL_BITS'(quo_w);

	assign pos_w = W'(pos_q);
	assign tgt_w = W'(tgt_q);
	assign arg_w = W'(arg_q);
	assign up_w  = W'(upper_q);
	assign lo_w  = W'(lower_q);

	assign stopped_now = posmode_q ? (pos_q == tgt_q) : (active_q == '0);
	assign home_ok     = in_limits('0, up_w, lo_w);
	assign mv_w        = (op_q == OP_REL) ? (arg_w + pos_w) : arg_w;

	always_comb begin
		pos_d     = pos_q;
		tgt_d     = tgt_q;
		active_d  = active_q;
		cd_d      = cd_q;
		posmode_d = posmode_q;
		dir_d     = dir_q;
		written_d = 1'b0;
		np_w      = pos_w;
		case (op_q) inside
			OP_TICK: begin
				if (cd_q != '0) begin
					cd_d = cd_q - 1'b1;
				end
				if (cd_q == '0 && active_q != '0 && !stopped_now) begin
					if (posmode_q) begin
						np_w = (tgt_q > pos_q) ? pos_w + W'(1) : pos_w - W'(1);
					end else begin
						np_w = dir_q ? pos_w + W'(1) : pos_w - W'(1);
					end
					if (in_limits(np_w, up_w, lo_w)) begin
						pos_d     = POS_BITS'(np_w);
						written_d = 1'b1;
					end
					cd_d = active_q;
				end
			end
			OP_ABS, OP_REL: begin
				posmode_d = 1'b1;
				active_d  = step_ivl_q;
				if (step_ivl_q != '0) begin
					cd_d  = step_ivl_q;
					tgt_d = POS_BITS'(clamp(mv_w, up_w, lo_w));
					dir_d = (arg_q > 0);
				end
			end
			OP_SPEED: begin
				posmode_d = 1'b0;
				dir_d     = (arg_q > 0);
				active_d  = speed_ivl;
				cd_d      = speed_ivl;
			end
			OP_STOP: begin
				tgt_d    = pos_q;
				active_d = '0;
			end
			OP_SET: begin
				if (in_limits(arg_w, up_w, lo_w)) begin
					pos_d     = POS_BITS'(arg_w);
					written_d = 1'b1;
				end
			end
			OP_HOME: begin
				posmode_d = 1'b1;
				active_d  = step_ivl_q;
				if (step_ivl_q != '0) begin
					cd_d  = step_ivl_q;
					dir_d = 1'b0;
				end
				if (home_ok) begin
					pos_d     = '0;
					written_d = 1'b1;
					tgt_d     = '0;
				end else begin
					tgt_d = pos_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q    <= POS_BITS'(180);
			lower_q    <= -POS_BITS'(180);
			step_ivl_q <= INTERVAL_BITS'(5);
			pos_q      <= '0;
			tgt_q      <= '0;
			active_q   <= INTERVAL_BITS'(5);
			cd_q       <= INTERVAL_BITS'(5);
			posmode_q  <= 1'b1;
			dir_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_UPPER: upper_q    <= cfg_data[POS_BITS-1:0];
					CFG_LOWER: lower_q    <= cfg_data[POS_BITS-1:0];
					CFG_STEP:  step_ivl_q <= cfg_data[INTERVAL_BITS-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.exec) begin
				pos_q     <= pos_d;
				tgt_q     <= tgt_d;
				active_q  <= active_d;
				cd_q      <= cd_d;
				posmode_q <= posmode_d;
				dir_q     <= dir_d;
			end
		end
	end

	// report fields, taken from the updated state
	assign diff_w = tgt_w - pos_w;
	assign dist_w = diff_w[W-1] ? -diff_w : diff_w;
	assign pwm_w  = pos_w + W'(PWM_OFFSET);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= opcode_t'(in_opcode);
			arg_q <= in_argument;
		end
		if (cmd.exec) begin
			written_q <= written_d;
		end
		if (cmd.load_out) begin
			result_q <= OUT_BITS'({dist_w[POS_BITS-1:0], posmode_q, dir_q, pos_q == '0,
			                       stopped_now, written_q, pwm_w[POS_BITS-1:0], pos_q});
		end
	end

	assign result = result_q;

endmodule

[rtl/servo_slew_position_controller.sv]
// Slew-limited servo positioner in half-degree units. Each command on the
// slave stream (opcode in s_tuser: tick, move absolute, move relative, speed
// move, stop, set position, home; argument in s_tdata) yields exactly one
// status transaction on the master stream: position, PWM count (position +
// 284), a flag for a position write, stopped, at-home, direction, mode and
// distance to target. Position moves step one half degree per step_interval + 1
// ticks toward a target clamped to the limits; a speed move steps every
// 500/|speed| + 1 ticks in the sign's direction. Steps or sets outside the limits
// are dropped. One command is worked at a time; a speed move takes its interval
// from a bit-serial restoring divider. A result that is not yet taken holds the
// block in its response state only once the next result is ready. The config
// port writes registers (0 upper limit, 1 lower limit, 2 step interval); the user
// must do so only while the block is idle, and the block itself does not enforce it.
module servo_slew_position_controller import ssp_pkg::*; #(
	parameter int POS_BITS      = 9,
	parameter int INTERVAL_BITS = 10,
	localparam int CFG_BITS = (POS_BITS > INTERVAL_BITS) ? POS_BITS : INTERVAL_BITS,
	localparam int RAW_BITS = 3 * POS_BITS + 5,
	localparam int OUT_BITS = ((RAW_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// command stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ARG_TDATA_BITS-1:0] s_tdata,  // argument[10:0], zero fill
	input  logic [OP_BITS-1:0]        s_tuser,  // opcode[2:0]
	// status stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// from bit 0 up: position, pwm_count, pwm_written, stopped, at_home,
	// moving_up, position_mode, distance_left, zero fill
	output logic [OUT_BITS-1:0]       m_tdata,
	// register writes
	input  logic                      cfg_we,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: accept, optional divide, apply, present
	ssp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// state, config registers, divider and result register
	ssp_datapath #(
		.POS_BITS      (POS_BITS),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_opcode   (s_tuser),
		.in_argument (s_tdata[ARG_BITS-1:0]),
		.cmd         (cmd),
		.status      (status),
		.result      (m_tdata)
	);

endmodule

[tb/sv/servo_slew_position_controller_test.sv]
`timescale 1ns / 1ps

// Servo positioner check: commands go in on the s_ stream with random gaps,
// status comes back on the m_ stream under random back-pressure, and every
// status transaction is checked field by field against a cycle-free model
// of the positioner kept in this file.
module servo_slew_position_controller_test;
	import ssp_pkg::*;

	// opcode 7 has no meaning; the block only reports its state
	localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;
	localparam int CFG_W           = 10;
	localparam int MAX_REPORTS     = 10;
	localparam int PHASE_COMMANDS  = 290;
	localparam int DRAIN_CYCLES    = 40;
	localparam int MAX_IVL         = 1023;

	// m_tdata layout, lowest bit last
	typedef struct packed {
		logic [8:0]        distance_left;
		logic              position_mode;
		logic              moving_up;
		logic              at_home;
		logic              stopped;
		logic              pwm_written;
		logic [8:0]        pwm_count;
		logic signed [8:0] position;
	} status_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [ARG_TDATA_BITS-1:0] s_tdata   = '0;  // argument[10:0], zero fill
	logic [OP_BITS-1:0]        s_tuser   = OP_TICK;  // opcode[2:0]
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	// position, pwm_count, pwm_written, stopped, at_home, moving_up,
	// position_mode, distance_left
	logic [31:0]               m_tdata;
	logic                      cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]   cfg_index = CFG_UPPER;
	logic [CFG_W-1:0]          cfg_data  = '0;

	servo_slew_position_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Positioner model: registers and state as the block keeps them
	// ---------------------------------------------------------------
	int upper_lim, lower_lim, step_ivl;
	int cur_pos, tgt_pos, act_ivl, tick_count;
	bit pos_mode, dir_up;

	status_t pending_status[$];  // statuses owed by the block, oldest first

	// run bookkeeping
	int  fault_count;
	int  commands_sent, statuses_seen, position_writes, speed_moves;
	int  register_writes, settings_used;
	bit  steady;  // no idling on either side while set

	function automatic int clamp_to_limits(int t);
		if (t > upper_lim) t = upper_lim;
		if (t < lower_lim) t = lower_lim;
		return t;
	endfunction

	// drop the write when it would leave the allowed window
	function automatic bit move_to(int p);
		if (p > upper_lim || p < lower_lim) return 1'b0;
		cur_pos = p;
		return 1'b1;
	endfunction

	function automatic bit halted();
		if (!pos_mode) return act_ivl == 0;
		return cur_pos == tgt_pos;
	endfunction

	function automatic void start_move(int t, bit up);
		pos_mode = 1'b1;
		act_ivl  = step_ivl;
		// a zero interval only selects position mode
		if (act_ivl > 0) begin
			tick_count = act_ivl;
			tgt_pos    = clamp_to_limits(t);
			dir_up     = up;
		end
	endfunction

	function automatic status_t predict_status(logic [OP_BITS-1:0] op,
			logic signed [ARG_BITS-1:0] arg);
		int      a, mag, ivl, gap, next_pos;
		bit      written, due;
		status_t s;
		a       = int'(arg);
		written = 1'b0;
		case (op)
			OP_TICK: begin
				due = (tick_count == 0);
				if (tick_count > 0) tick_count--;
				if (due && act_ivl > 0 && !halted()) begin
					if (pos_mode)
						next_pos = (tgt_pos > cur_pos) ? cur_pos + 1 : cur_pos - 1;
					else
						next_pos = dir_up ? cur_pos + 1 : cur_pos - 1;
					written    = move_to(next_pos);
					// a rejected step still reloads the countdown
					tick_count = act_ivl;
				end
			end
			OP_ABS: start_move(a, a > 0);
			OP_REL: start_move(a + cur_pos, a > 0);
			OP_SPEED: begin
				mag      = (a < 0) ? -a : a;
				ivl      = 0;
				pos_mode = 1'b0;
				dir_up   = a > 0;
				if (mag != 0) begin
					ivl = 500 / mag;
					if (ivl > MAX_IVL) ivl = MAX_IVL;
				end
				act_ivl    = ivl;
				tick_count = ivl;
			end
			OP_STOP: begin
				tgt_pos = cur_pos;
				act_ivl = 0;
			end
			OP_SET: written = move_to(a);
			OP_HOME: begin
				written = move_to(0);
				start_move(0, 1'b0);
				tgt_pos = cur_pos;
			end
			default: ;
		endcase
		gap = tgt_pos - cur_pos;
		if (gap < 0) gap = -gap;
		s.position      = 9'(cur_pos);
		s.pwm_count     = 9'(cur_pos + PWM_OFFSET);
		s.pwm_written   = written;
		s.stopped       = halted();
		s.at_home       = (cur_pos == 0);
		s.moving_up     = dir_up;
		s.position_mode = pos_mode;
		s.distance_left = 9'(gap);
		if (written) position_writes++;
		return s;
	endfunction

	function automatic string status_text(status_t s);
		return $sformatf("pos=%0d pwm=%0d wr=%b stop=%b home=%b up=%b mode=%b dist=%0d",
			s.position, s.pwm_count, s.pwm_written, s.stopped, s.at_home,
			s.moving_up, s.position_mode, s.distance_left);
	endfunction

	task automatic note_fault(string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("[%0t] error: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------
	// Status checker: one expectation consumed per status transaction
	// ---------------------------------------------------------------
	always @(posedge clk) begin : check_status
		status_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			statuses_seen++;
			if (pending_status.size() == 0) begin
				note_fault($sformatf("status with nothing pending: %s", status_text(got)));
			end else begin
				want = pending_status.pop_front();
				if (got.position !== want.position ||
						got.pwm_count !== want.pwm_count ||
						got.pwm_written !== want.pwm_written ||
						got.stopped !== want.stopped ||
						got.at_home !== want.at_home ||
						got.moving_up !== want.moving_up ||
						got.position_mode !== want.position_mode ||
						got.distance_left !== want.distance_left)
					note_fault($sformatf("status %0d mismatch\n  want %s\n  got  %s",
						statuses_seen, status_text(want), status_text(got)));
			end
		end
	end

	// Sink side back-pressure: stall with a chance of about 16 in a hundred, never while steady
	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= 16);

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Present one command; the model runs at the accepting edge.
	// The caller is always at a rising edge here.
	task automatic send_command(logic [OP_BITS-1:0] op, logic signed [ARG_BITS-1:0] arg);
		if (!steady && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(ARG_TDATA_BITS - ARG_BITS){1'b0}}, arg};
		do @(posedge clk); while (!s_tready);
		pending_status.push_back(predict_status(op, arg));
		commands_sent++;
		if (op == OP_SPEED) speed_moves++;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_command(OP_TICK, '0);
	endtask

	// Stop sending and wait for every owed status to come back.
	task automatic drain_statuses();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	// All three registers, one per cycle, only with the block idle
	task automatic apply_settings(int upper, int lower, int step);
		logic signed [8:0] lim;
		drain_statuses();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_UPPER;
		cfg_data  <= CFG_W'(upper);
		@(posedge clk);
		lim       = upper[8:0];
		upper_lim = int'(lim);
		cfg_index <= CFG_LOWER;
		cfg_data  <= CFG_W'(lower);
		@(posedge clk);
		lim       = lower[8:0];
		lower_lim = int'(lim);
		cfg_index <= CFG_STEP;
		cfg_data  <= CFG_W'(step);
		@(posedge clk);
		step_ivl  = step & MAX_IVL;
		cfg_we    <= 1'b0;
		register_writes += 3;
		settings_used++;
	endtask

	function automatic int random_position();
		if ($urandom_range(99) < 75) return int'($urandom_range(0, 400)) - 200;
		return int'($urandom_range(0, 2047)) - 1024;
	endfunction

	function automatic int random_offset();
		if ($urandom_range(99) < 70) return int'($urandom_range(0, 80)) - 40;
		return int'($urandom_range(0, 2047)) - 1024;
	endfunction

	// fast speeds keep the step interval short so motion shows up
	function automatic int random_speed();
		int mag;
		if ($urandom_range(99) < 70) begin
			mag = $urandom_range(40, 1023);
			return $urandom_range(1) ? mag : -mag;
		end
		return int'($urandom_range(0, 2047)) - 1024;
	endfunction

	function automatic int random_limit();
		return int'($urandom_range(0, 360)) - 180;
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset settings: clamping at both ends, both modes, stop, rejected
	// sets just past the limits, home, the unused opcode, argument extremes.
	task automatic test_commands_at_reset();
		send_command(OP_TICK, '0);
		send_command(OP_ABS, 11'sd1023);        // target clamps to the upper limit
		send_ticks(6);                           // first step on the sixth tick
		send_command(OP_STOP, '0);
		send_command(OP_REL, -11'sd1024);        // down, clamps to the lower limit
		send_command(OP_SPEED, 11'sd1);          // slowest speed, longest interval
		send_command(OP_SPEED, -11'sd1024);      // too fast: interval zero, halted
		send_command(OP_SPEED, -11'sd500);       // one step every two ticks, downward
		send_ticks(3);
		send_command(OP_SET, 11'sd180);
		send_command(OP_SET, 11'sd181);          // rejected
		send_command(OP_SET, -11'sd180);
		send_command(OP_SET, -11'sd181);         // rejected
		send_command(OP_HOME, '0);
		send_command(OP_UNUSED, 11'sd1023);
		send_command(OP_SPEED, '0);
		send_command(OP_ABS, -11'sd1024);
		send_command(OP_ABS, '0);
	endtask

	// Step interval zero freezes position moves but not speed moves;
	// the widest interval never gets to its first step here.
	task automatic test_interval_extremes();
		apply_settings(180, -180, 0);
		send_command(OP_ABS, 11'sd50);
		send_ticks(2);
		send_command(OP_REL, 11'sd10);
		send_command(OP_SPEED, 11'sd250);
		send_ticks(3);
		apply_settings(180, -180, MAX_IVL);
		send_command(OP_ABS, -11'sd20);
		send_ticks(3);
		apply_settings(180, -180, 1);
		send_command(OP_ABS, 11'sd3);
		send_ticks(8);
	endtask

	// Widest limits (PWM count wraps), home outside the window,
	// and a window whose lower limit is above its upper limit.
	task automatic test_limit_corners();
		apply_settings(255, -256, 1);
		send_command(OP_SET, 11'sd255);
		send_command(OP_SET, -11'sd256);
		send_command(OP_HOME, '0);
		apply_settings(50, 10, 1);
		send_command(OP_HOME, '0);               // zero lies outside: rejected
		send_command(OP_SET, 11'sd30);
		send_command(OP_ABS, '0);                // clamps up to the lower limit
		send_ticks(4);
		apply_settings(-20, 20, 2);
		send_command(OP_ABS, 11'sd100);
		send_command(OP_SET, '0);
		send_ticks(4);
	endtask

	// Mostly ticks so that moves actually run out; commands in between.
	task automatic run_random_phase(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 52)
				send_command(OP_TICK, ARG_BITS'(int'($urandom_range(0, 2047)) - 1024));
			else if (r < 62) send_command(OP_ABS, ARG_BITS'(random_position()));
			else if (r < 72) send_command(OP_REL, ARG_BITS'(random_offset()));
			else if (r < 80) send_command(OP_SPEED, ARG_BITS'(random_speed()));
			else if (r < 84) send_command(OP_STOP, ARG_BITS'(random_offset()));
			else if (r < 92) send_command(OP_SET, ARG_BITS'(random_position()));
			else if (r < 97) send_command(OP_HOME, ARG_BITS'(random_offset()));
			else             send_command(OP_UNUSED, ARG_BITS'(random_position()));
		end
	endtask

	task automatic test_random_traffic();
		int upper, lower, t;
		for (int phase = 0; phase < 6; phase++) begin
			upper = random_limit();
			lower = random_limit();
			// keep most windows the right way round
			if (lower > upper && $urandom_range(9) != 0) begin
				t     = upper;
				upper = lower;
				lower = t;
			end
			case (phase)
				0: apply_settings(180, -180, 5);
				1: apply_settings(180, -180, 1);
				2: apply_settings(upper, lower, 2);
				3: apply_settings(255, -256, 3);
				4: apply_settings(upper, lower, $urandom_range(0, 3));
				default: apply_settings(upper, lower, $urandom_range(1, 6));
			endcase
			steady = (phase == 1);
			run_random_phase(PHASE_COMMANDS);
			steady = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		upper_lim  = 180;
		lower_lim  = -180;
		step_ivl   = 5;
		cur_pos    = 0;
		tgt_pos    = 0;
		act_ivl    = 5;
		tick_count = 5;
		pos_mode   = 1'b1;
		dir_up     = 1'b0;
		steady     = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands_at_reset();
		test_interval_extremes();
		test_limit_corners();
		test_random_traffic();

		drain_statuses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_status.size() != 0)
			note_fault($sformatf("%0d statuses never arrived", pending_status.size()));

		$display("covered %0d commands (%0d speed moves, %0d position writes), %0d statuses",
			commands_sent, speed_moves, position_writes, statuses_seen);
		$display("under %0d register settings (%0d register writes), %0d faults",
			settings_used, register_writes, fault_count);
		if (fault_count == 0)
			$display("servo_slew_position_controller_test: PASS");
		else
			$display("servo_slew_position_controller_test: FAIL");
		$finish;
	end

	// Watchdog: well beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("servo_slew_position_controller_test: FAIL");
		$finish;
	end

endmodule
